FILE: src/tsg_pkg.sv
// Shared types, constants and helpers for the tilt-driven sand grid step unit.
// No dependencies; the step unit, multiplier, side count and cell step files use it by scoped names.
package tsg_pkg;

  // Grid side length: default and largest supported value
  localparam int GRID_SIZE_DEF = 8;
  localparam int GRID_MAX      = 16;

  // Rotated axis magnitudes fit 17 bits (largest is 65536)
  localparam int AXW   = 18;
  localparam int MAG_W = 17;

  // Fixed-point slope constants: 1000*|yy| against 2414*|xx| and 414*|xx|
  localparam int KW = 12;
  localparam logic [KW-1:0] K_SCALE   = 12'd1000;
  localparam logic [KW-1:0] K_DIAG_HI = 12'd2414;
  localparam logic [KW-1:0] K_DIAG_LO = 12'd414;
  localparam int PW = MAG_W + KW;

  // Multiplier operand slots, one per sequencer step
  localparam logic [1:0] MS_AY    = 2'd0;
  localparam logic [1:0] MS_AX_HI = 2'd1;
  localparam logic [1:0] MS_AX_LO = 2'd2;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HAND  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIR   = 7'b0001000,
    S_COUNT = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // Move direction for one pass, plus the tie-break for the current grid
  typedef struct packed {
    logic ix_en;
    logic ix_neg;
    logic iy_en;
    logic iy_neg;
    logic tie_x;   // both single axes free: move in x
  } dir_t;

  // Magnitude of an 18-bit signed value
  function automatic logic [MAG_W-1:0] mag18(input logic signed [AXW-1:0] v);
    logic [AXW-1:0] n;
    n = v[AXW-1] ? AXW'(-v) : AXW'(v);
    return n[MAG_W-1:0];
  endfunction

  // Upper grid reset: full except cells with x+y <= 2, bit x+n*y
  function automatic logic [GRID_MAX*GRID_MAX-1:0] upper_reset(input int n);
    logic [GRID_MAX*GRID_MAX-1:0] r;
    r = '0;
    for (int y = 0; y < GRID_MAX; y++) begin
      for (int x = 0; x < GRID_MAX; x++) begin
        if (x < n && y < n && x + y > 2) r[x + n * y] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/tsg_in_if.sv
// Input channel: one accelerometer sample per item, valid/ready handshake.
// No dependencies.
interface tsg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

FILE: src/tsg_out_if.sv
// Output channel: one grid row per item, valid/ready handshake.
// No dependencies.
interface tsg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] row_index;
  logic [7:0] upper_row;
  logic [7:0] lower_row;
  logic       moved;
  logic       last;

  modport source (output valid, output row_index, output upper_row,
                  output lower_row, output moved, output last, input ready);
  modport sink (input valid, input row_index, input upper_row,
                input lower_row, input moved, input last, output ready);
endinterface

FILE: src/tilt_driven_sand_grid_step_unit.sv
// Tilt-driven sand grid step: one sample in, min(GRID_SIZE,8) row items out.
// A corner handoff or flat tilt goes straight to row output; otherwise the
// multiplier steps, direction, column counts and the one-cell-per-cycle walk come first.
// Rows leave one per cycle while out ready is high; a new sample is taken only
// after the last row has left.
// Synchronous reset loads the upper start pattern, clears the lower grid, goes idle.
module tilt_driven_sand_grid_step_unit #(
  parameter int GRID_SIZE = tsg_pkg::GRID_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tsg_in_if.sink    in_ch,
  tsg_out_if.source out_ch
);

  localparam int NN    = GRID_SIZE * GRID_SIZE;
  localparam int CW    = $clog2(NN);
  localparam int XW    = $clog2(GRID_SIZE);
  localparam int SW    = $clog2(GRID_SIZE + 1);
  localparam int CNTW  = $clog2(NN + 1);
  localparam int ROWS  = (GRID_SIZE < 8) ? GRID_SIZE : 8;
  localparam int RW    = $clog2(ROWS);
  localparam int GRAINS = NN - 6;
  localparam logic [tsg_pkg::GRID_MAX*tsg_pkg::GRID_MAX-1:0] UP_FULL =
    tsg_pkg::upper_reset(GRID_SIZE);
  localparam logic [NN-1:0] UP_INIT = UP_FULL[NN-1:0];
  localparam logic [XW-1:0] EDGE = XW'(GRID_SIZE - 1);

  tsg_pkg::state_t state;

  logic [NN-1:0] upper, lower, work, work_next;
  logic signed [tsg_pkg::AXW-1:0] xx, yy;
  logic [tsg_pkg::MAG_W-1:0] azz, axx, ayy;
  logic [tsg_pkg::PW-1:0]    p_a, p_b, prod;
  logic [1:0]                mstep;
  logic [tsg_pkg::MAG_W-1:0] mul_a;
  logic [tsg_pkg::KW-1:0]    mul_b;
  tsg_pkg::dir_t             dir_base, dir;
  logic [CNTW-1:0] cnt_lu, cnt_ru, cnt_ll, cnt_rl, cur_l, cur_r;
  logic [SW-1:0]   col_ru, col_lu, col_rl, col_ll;
  logic [XW-1:0]   col, cx, cy;
  logic            gsel, any_moved, moved;
  logic            ypos, swap;
  logic            go;
  logic [CW-1:0]   src, dst;
  logic [RW-1:0]   row;
  logic [CW-1:0]   row_base;
  logic [7:0]      urow, lrow;

  assign axx  = tsg_pkg::mag18(xx);
  assign ayy  = tsg_pkg::mag18(yy);
  assign ypos = !yy[tsg_pkg::AXW-1] && (yy != '0);
  assign swap = xx[tsg_pkg::AXW-1] && yy[tsg_pkg::AXW-1];

  // shared multiplier operand select
  always_comb begin
    case (mstep)
      tsg_pkg::MS_AY:    begin mul_a = ayy; mul_b = tsg_pkg::K_SCALE;   end
      tsg_pkg::MS_AX_HI: begin mul_a = axx; mul_b = tsg_pkg::K_DIAG_HI; end
      tsg_pkg::MS_AX_LO: begin mul_a = axx; mul_b = tsg_pkg::K_DIAG_LO; end
      default:           begin mul_a = axx; mul_b = tsg_pkg::K_DIAG_LO; end
    endcase
  end

  tsg_mul #(.AW(tsg_pkg::MAG_W), .BW(tsg_pkg::KW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // per-column diagonal counts for both grids
  tsg_side_count #(.GRID_SIZE(GRID_SIZE)) u_cnt_upper (
    .grid(upper), .col(col), .right_cnt(col_ru), .left_cnt(col_lu)
  );
  tsg_side_count #(.GRID_SIZE(GRID_SIZE)) u_cnt_lower (
    .grid(lower), .col(col), .right_cnt(col_rl), .left_cnt(col_ll)
  );

  // tie-break for the grid under walk
  assign cur_l = gsel ? cnt_ll : cnt_lu;
  assign cur_r = gsel ? cnt_rl : cnt_ru;
  always_comb begin
    dir       = dir_base;
    dir.tie_x = swap ? (cur_r >= cur_l) : (cur_l >= cur_r);
  end

  tsg_cell_step #(.GRID_SIZE(GRID_SIZE)) u_step (
    .grid (gsel ? lower : upper),
    .work (work),
    .cx   (cx),
    .cy   (cy),
    .dir  (dir),
    .go   (go),
    .src  (src),
    .dst  (dst)
  );

  // apply one move to the working copy
  always_comb begin
    work_next = work;
    if (go) begin
      work_next[src] = 1'b0;
      work_next[dst] = 1'b1;
    end
  end

  // sequencer and grid state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsg_pkg::S_IDLE;
      upper     <= UP_INIT;
      lower     <= '0;
      mstep     <= tsg_pkg::MS_AY;
      gsel      <= 1'b0;
      any_moved <= 1'b0;
      row       <= '0;
    end else begin
      case (state)
        tsg_pkg::S_IDLE: begin
          if (in_ch.valid) begin
            xx  <= tsg_pkg::AXW'(in_ch.accel_x) - tsg_pkg::AXW'(in_ch.accel_z);
            yy  <= -tsg_pkg::AXW'(in_ch.accel_z) - tsg_pkg::AXW'(in_ch.accel_x);
            azz <= tsg_pkg::mag18(tsg_pkg::AXW'(in_ch.accel_y));
            state <= tsg_pkg::S_HAND;
          end
        end
        tsg_pkg::S_HAND: begin
          row <= '0;
          if (ypos && upper[NN-1] && !lower[0]) begin
            upper[NN-1] <= 1'b0;
            lower[0]    <= 1'b1;
            moved       <= 1'b1;
            state       <= tsg_pkg::S_OUT;
          end else if (!ypos && lower[0] && !upper[NN-1]) begin
            lower[0]    <= 1'b0;
            upper[NN-1] <= 1'b1;
            moved       <= 1'b1;
            state       <= tsg_pkg::S_OUT;
          end else if (azz > axx && azz > ayy) begin
            moved <= 1'b0;
            state <= tsg_pkg::S_OUT;
          end else begin
            mstep <= tsg_pkg::MS_AY;
            state <= tsg_pkg::S_MUL;
          end
        end
        tsg_pkg::S_MUL: begin
          // product of the previous slot arrives each cycle
          case (mstep)
            tsg_pkg::MS_AY:    mstep <= tsg_pkg::MS_AX_HI;
            tsg_pkg::MS_AX_HI: begin
              p_a   <= prod;
              mstep <= tsg_pkg::MS_AX_LO;
            end
            default: begin
              p_b   <= prod;
              state <= tsg_pkg::S_DIR;
            end
          endcase
        end
        tsg_pkg::S_DIR: begin
          dir_base.tie_x <= 1'b0;
          if (xx == '0) begin
            dir_base.ix_en  <= 1'b0;
            dir_base.ix_neg <= 1'b0;
            dir_base.iy_en  <= 1'b1;
          end else begin
            dir_base.ix_en  <= p_a < p_b;
            dir_base.ix_neg <= xx[tsg_pkg::AXW-1];
            dir_base.iy_en  <= p_a > prod;
          end
          dir_base.iy_neg <= !ypos;
          cnt_lu <= '0;
          cnt_ru <= '0;
          cnt_ll <= '0;
          cnt_rl <= '0;
          col    <= '0;
          state  <= tsg_pkg::S_COUNT;
        end
        tsg_pkg::S_COUNT: begin
          cnt_lu <= cnt_lu + CNTW'(col_lu);
          cnt_ru <= cnt_ru + CNTW'(col_ru);
          cnt_ll <= cnt_ll + CNTW'(col_ll);
          cnt_rl <= cnt_rl + CNTW'(col_rl);
          if (col == EDGE) begin
            cx        <= '0;
            cy        <= '0;
            gsel      <= 1'b0;
            work      <= upper;
            any_moved <= 1'b0;
            state     <= tsg_pkg::S_WALK;
          end else begin
            col <= col + XW'(1);
          end
        end
        tsg_pkg::S_WALK: begin
          // x-major order: y inner
          any_moved <= any_moved | go;
          if (cy == EDGE) begin
            cy <= '0;
            if (cx == EDGE) begin
              cx <= '0;
              if (!gsel) begin
                upper <= work_next;
                work  <= lower;
                gsel  <= 1'b1;
              end else begin
                lower <= work_next;
                gsel  <= 1'b0;
                moved <= any_moved | go;
                state <= tsg_pkg::S_OUT;
              end
            end else begin
              work <= work_next;
              cx   <= cx + XW'(1);
            end
          end else begin
            work <= work_next;
            cy   <= cy + XW'(1);
          end
        end
        tsg_pkg::S_OUT: begin
          if (out_ch.ready) begin
            if (row == RW'(ROWS - 1)) begin
              row   <= '0;
              state <= tsg_pkg::S_IDLE;
            end else begin
              row <= row + RW'(1);
            end
          end
        end
        default: state <= tsg_pkg::S_IDLE;
      endcase
    end
  end

  // row extraction for the output item
  assign row_base = CW'(row) * CW'(GRID_SIZE);
  for (genvar gx = 0; gx < 8; gx++) begin : g_row
    if (gx < ROWS) begin : g_bit
      assign urow[gx] = upper[row_base + CW'(gx)];
      assign lrow[gx] = lower[row_base + CW'(gx)];
    end else begin : g_pad
      assign urow[gx] = 1'b0;
      assign lrow[gx] = 1'b0;
    end
  end

  assign in_ch.ready      = (state == tsg_pkg::S_IDLE);
  assign out_ch.valid     = (state == tsg_pkg::S_OUT);
  assign out_ch.row_index = 3'(row);
  assign out_ch.upper_row = urow;
  assign out_ch.lower_row = lrow;
  assign out_ch.moved     = moved;
  assign out_ch.last      = (row == RW'(ROWS - 1));

  // grains are never created or lost
  a_grains_kept: assert property (@(posedge clk) disable iff (rst)
    ($countones(upper) + $countones(lower)) == GRAINS)
    else $error("grain count changed");

  // each step of the walk moves grains, never adds or drops them
  a_walk_kept: assert property (@(posedge clk) disable iff (rst)
    (state == tsg_pkg::S_WALK) |->
      ($countones(work) == $countones(gsel ? lower : upper)))
    else $error("working copy lost a grain");

  // no sample taken while rows are still pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input accepted during row output");

endmodule

FILE: src/tsg_mul.sv
// Shared multiplier with registered product, used for the slope tests.
// Depends on tsg_pkg for default operand widths.
module tsg_mul #(
  parameter int AW = tsg_pkg::MAG_W,
  parameter int BW = tsg_pkg::KW
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p <= (AW+BW)'(a) * (AW+BW)'(b);
  end

endmodule

FILE: src/tsg_side_count.sv
// Diagonal side count for one column of a grid: grains above and below
// the diagonal. Depends on tsg_pkg for the default grid size.
module tsg_side_count #(
  parameter int GRID_SIZE = tsg_pkg::GRID_SIZE_DEF,
  localparam int NN = GRID_SIZE * GRID_SIZE,
  localparam int CW = $clog2(NN),
  localparam int XW = $clog2(GRID_SIZE),
  localparam int SW = $clog2(GRID_SIZE + 1)
) (
  input  logic [NN-1:0] grid,
  input  logic [XW-1:0] col,
  output logic [SW-1:0] right_cnt,  // cells with x > y
  output logic [SW-1:0] left_cnt    // cells with x < y
);

  // walk down the column; rows are independent
  always_comb begin
    logic [CW-1:0] idx;
    right_cnt = '0;
    left_cnt  = '0;
    for (int y = 0; y < GRID_SIZE; y++) begin
      idx = CW'(y * GRID_SIZE) + CW'(col);
      if (grid[idx]) begin
        if (XW'(y) < col) right_cnt = right_cnt + SW'(1);
        else if (XW'(y) > col) left_cnt = left_cnt + SW'(1);
      end
    end
  end

endmodule

FILE: src/tsg_cell_step.sv
// Move decision for one cell of the pass: target, single-axis fallback,
// tie-break. Depends on tsg_pkg for dir_t and the default grid size.
module tsg_cell_step #(
  parameter int GRID_SIZE = tsg_pkg::GRID_SIZE_DEF,
  localparam int NN = GRID_SIZE * GRID_SIZE,
  localparam int CW = $clog2(NN),
  localparam int XW = $clog2(GRID_SIZE)
) (
  input  logic [NN-1:0]     grid,   // grid at start of pass
  input  logic [NN-1:0]     work,   // working copy
  input  logic [XW-1:0]     cx,
  input  logic [XW-1:0]     cy,
  input  tsg_pkg::dir_t     dir,
  output logic              go,
  output logic [CW-1:0]     src,
  output logic [CW-1:0]     dst
);

  localparam logic [XW-1:0] EDGE = XW'(GRID_SIZE - 1);

  logic [XW-1:0] nx, ny;
  logic [CW-1:0] tgt_idx, ydir_idx, xdir_idx;
  logic          fy, fx;

  // clamped diagonal target
  always_comb begin
    nx = cx;
    ny = cy;
    if (dir.ix_en) begin
      if (dir.ix_neg) nx = (cx == '0) ? cx : cx - XW'(1);
      else            nx = (cx == EDGE) ? cx : cx + XW'(1);
    end
    if (dir.iy_en) begin
      if (dir.iy_neg) ny = (cy == '0) ? cy : cy - XW'(1);
      else            ny = (cy == EDGE) ? cy : cy + XW'(1);
    end
  end

  assign src      = CW'(cy) * CW'(GRID_SIZE) + CW'(cx);
  assign tgt_idx  = CW'(ny) * CW'(GRID_SIZE) + CW'(nx);
  assign ydir_idx = CW'(ny) * CW'(GRID_SIZE) + CW'(cx);  // (x, ny)
  assign xdir_idx = CW'(cy) * CW'(GRID_SIZE) + CW'(nx);  // (nx, y)
  assign fy       = !work[ydir_idx];
  assign fx       = !work[xdir_idx];

  // blocked diagonal falls back to one axis
  always_comb begin
    go  = 1'b0;
    dst = tgt_idx;
    if (grid[src] && !(nx == cx && ny == cy)) begin
      if (!work[tgt_idx]) begin
        go = 1'b1;
      end else if (fy && fx) begin
        go  = 1'b1;
        dst = dir.tie_x ? xdir_idx : ydir_idx;
      end else if (fy) begin
        go  = 1'b1;
        dst = ydir_idx;
      end else if (fx) begin
        go  = 1'b1;
        dst = xdir_idx;
      end
    end
  end

endmodule
